// ===== sv/fpfa_pkg.sv =====
// Shared types and constants for the fixed partition fit allocator.
// No dependencies; every other file imports this package.
package fpfa_pkg;

	localparam int PARTITION_COUNT = 16;
	localparam int SIZE_W = 10;
	localparam int IDX_W = (PARTITION_COUNT > 1) ? $clog2(PARTITION_COUNT) : 1;
	localparam int LOAD_W = 4;
	// wide enough to compare a load index with a cell position without truncation
	localparam int CMP_W = (IDX_W > LOAD_W) ? IDX_W : LOAD_W;

	typedef enum logic [1:0] {
		MODE_FIRST = 2'd0,
		MODE_BEST  = 2'd1,
		MODE_WORST = 2'd2,
		MODE_LOAD  = 2'd3
	} mode_t;

	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_NOFIT     = 2'd1;
	localparam logic [1:0] ST_LOADED    = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HOLD
	} state_t;

	typedef struct packed {
		mode_t              mode;
		logic [SIZE_W-1:0]  req_size;
		logic [LOAD_W-1:0]  load_index;
	} req_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [LOAD_W-1:0]  block_index;
	} rsp_word_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic               active;
		mode_t              policy;
		logic [SIZE_W-1:0]  need;
		logic               found;
		logic [IDX_W-1:0]   idx;
		logic [SIZE_W-1:0]  best_size;
	} hop_t;

	// broadcast writes to the cell row
	typedef struct packed {
		logic               load_en;
		logic [LOAD_W-1:0]  load_index;
		logic [SIZE_W-1:0]  load_size;
		logic               clr_en;
		logic [IDX_W-1:0]   clr_idx;
	} cell_ctrl_t;

endpackage

// ===== sv/fpfa_cell.sv =====
// One partition cell: holds a size and a free flag, updates the passing search token.
// Depends on fpfa_pkg.
module fpfa_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [fpfa_pkg::IDX_W-1:0]  position,
	input  fpfa_pkg::cell_ctrl_t        ctrl,
	input  fpfa_pkg::hop_t              hop_in,
	output fpfa_pkg::hop_t              hop_q
);
	import fpfa_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic              free_q;
	logic              fits;
	logic              load_hit;
	logic              clr_hit;
	hop_t              hop_nxt;

	assign load_hit = ctrl.load_en && (CMP_W'(ctrl.load_index) == CMP_W'(position));
	assign clr_hit  = ctrl.clr_en && (ctrl.clr_idx == position);
	assign fits     = free_q && (size_q >= hop_in.need);

	always_comb begin
		hop_nxt = hop_in;
		if (hop_in.active && fits) begin
			if (!hop_in.found) begin
				hop_nxt.found     = 1'b1;
				hop_nxt.idx       = position;
				hop_nxt.best_size = size_q;
			end else if (hop_in.policy == MODE_BEST && size_q < hop_in.best_size) begin
				hop_nxt.idx       = position;
				hop_nxt.best_size = size_q;
			end else if (hop_in.policy == MODE_WORST && size_q > hop_in.best_size) begin
				hop_nxt.idx       = position;
				hop_nxt.best_size = size_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_q  <= '0;
			free_q <= 1'b0;
		end else begin
			hop_q <= hop_nxt;
			if (load_hit) begin
				free_q <= 1'b1;
			end else if (clr_hit) begin
				free_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_hit) begin
			size_q <= ctrl.load_size;
		end
	end

endmodule

// ===== sv/fpfa_chain.sv =====
// Row of partition cells; the search token moves one cell per cycle from head to tail.
// Depends on fpfa_pkg and fpfa_cell.
module fpfa_chain (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fpfa_pkg::cell_ctrl_t  ctrl,
	input  fpfa_pkg::hop_t        head,
	output fpfa_pkg::hop_t        tail
);
	import fpfa_pkg::*;

	hop_t links [0:PARTITION_COUNT];

	assign links[0] = head;
	assign tail     = links[PARTITION_COUNT];

	for (genvar i = 0; i < PARTITION_COUNT; i++) begin : g_cell
		fpfa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.position (IDX_W'(i)),
			.ctrl     (ctrl),
			.hop_in   (links[i]),
			.hop_q    (links[i+1])
		);
	end

endmodule

// ===== sv/fixed_partition_fit_allocator.sv =====
// Top level of the fixed partition fit allocator: control, result register, assertions.
// Depends on fpfa_pkg and fpfa_chain.
//
// Usage:
//   Request channel (req_valid, req_stall, req): one word per item, mode selects
//   first, best or worst fit, or a load of one partition's size.
//   Response channel (rsp_valid, rsp_stall, rsp): exactly one word per item,
//   status and partition index.
// Flow:
//   A load is answered from the response register, written as the request is taken.
//   An allocation runs its search token down a row of PARTITION_COUNT cells, one
//   cell per cycle, and answers from the response register once it leaves the tail.
//   One item is in flight at a time; req_stall stays high from acceptance until
//   the response word is taken, so the next item enters the cycle after that.
// Reset:
//   arst_n clears every free flag (nothing can be allocated until loaded),
//   the search row and the control state. Sizes are held without reset.
// Receiver stall:
//   The response word holds in its register while rsp_stall is high.
module fixed_partition_fit_allocator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  fpfa_pkg::req_word_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output fpfa_pkg::rsp_word_t  rsp
);
	import fpfa_pkg::*;

	state_t     state_q;
	state_t     state_nxt;
	rsp_word_t  rsp_q;
	rsp_word_t  rsp_nxt;
	logic       rsp_load;
	logic       req_take;
	logic       is_load;
	logic       load_ok;
	cell_ctrl_t ctrl;
	hop_t       head;
	hop_t       tail;

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign is_load   = (req.mode == MODE_LOAD);
	assign load_ok   = int'(req.load_index) < PARTITION_COUNT;

	always_comb begin
		ctrl            = '0;
		ctrl.load_en    = req_take && is_load && load_ok;
		ctrl.load_index = req.load_index;
		ctrl.load_size  = req.req_size;
		// mark the winner allocated as the token leaves the row
		ctrl.clr_en     = tail.active && tail.found;
		ctrl.clr_idx    = tail.idx;
	end

	always_comb begin
		head        = '0;
		head.active = req_take && !is_load;
		head.policy = req.mode;
		head.need   = req.req_size;
	end

	fpfa_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.head   (head),
		.tail   (tail)
	);

	always_comb begin
		state_nxt = state_q;
		rsp_nxt   = rsp_q;
		rsp_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_take) begin
					if (is_load) begin
						rsp_load  = 1'b1;
						state_nxt = S_HOLD;
						if (load_ok) begin
							rsp_nxt.status      = ST_LOADED;
							rsp_nxt.block_index = req.load_index;
						end else begin
							rsp_nxt.status      = ST_NOFIT;
							rsp_nxt.block_index = '0;
						end
					end else begin
						state_nxt = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (tail.active) begin
					rsp_load  = 1'b1;
					state_nxt = S_HOLD;
					if (tail.found) begin
						rsp_nxt.status      = ST_ALLOCATED;
						rsp_nxt.block_index = LOAD_W'(tail.idx);
					end else begin
						rsp_nxt.status      = ST_NOFIT;
						rsp_nxt.block_index = '0;
					end
				end
			end
			S_HOLD: begin
				if (!rsp_stall) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = (state_q == S_HOLD);
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// the token reaches the tail only while a search is pending
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.active |-> (state_q == S_SCAN))
		else $error("search token at tail outside of a scan");

	// a finished search always produces a response word next cycle
	a_tail_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		tail.active |=> rsp_valid)
		else $error("finished search gave no response");

	// no new item while a response is outstanding
	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_take)
		else $error("request taken while response pending");

	// a failed fit reports index zero
	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_NOFIT) |-> (rsp.block_index == '0))
		else $error("no-fit response with nonzero index");
`endif

endmodule
